// ----- rtl/mm_pkg.sv -----
// Shared types for the multiprecision multiplier.
// No dependencies; imported by mm_front, mm_back and multiprecision_multiplier.
`timescale 1ns / 1ps

package mm_pkg;

	localparam int LIMB_W = 64;

	typedef logic [LIMB_W-1:0] limb_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic take;	// back end pops the queued job this cycle
		logic busy;	// back end reads the factor stores
	} back_stat_t;

endpackage

// ----- rtl/mm_front.sv -----
// Front end: accepts limb items, sorts them into the two factor stores and
// queues one product job. Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_front #(
	parameter int MAX_LIMBS = 64,
	localparam int AW = $clog2(MAX_LIMBS),
	localparam int LW = $clog2(MAX_LIMBS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operand_select,
	input  mm_pkg::limb_t      limb_value,
	input  logic               operand_negative,
	input  logic               last_limb,
	input  mm_pkg::back_stat_t stat,
	output logic               wr_en_a,
	output logic               wr_en_b,
	output logic [AW-1:0]      wr_addr,
	output mm_pkg::limb_t      wr_data,
	output logic               job_valid,
	output logic [LW-1:0]      job_la,
	output logic [LW-1:0]      job_lb,
	output logic               job_neg
);
	import mm_pkg::*;

	logic [LW-1:0] a_len_q, b_len_q;
	logic          a_closed_q, b_closed_q;
	logic          a_sign_q;
	logic [LW-1:0] a_base, b_base, a_next, b_next;
	logic          a_room, b_room, accept;
	logic          job_v_q, job_neg_q;
	logic [LW-1:0] job_la_q, job_lb_q;

	// A closed operand restarts at limb zero.
	assign a_base = a_closed_q ? '0 : a_len_q;
	assign b_base = b_closed_q ? '0 : b_len_q;
	assign a_room = a_base < LW'(MAX_LIMBS);
	assign b_room = b_base < LW'(MAX_LIMBS);
	assign a_next = a_room ? a_base + LW'(1) : a_base;
	assign b_next = b_room ? b_base + LW'(1) : b_base;

	// Stores are shared with the back end: hold off while it reads them
	// or while a job waits.
	assign in_ready = !job_v_q && !stat.busy;
	assign accept   = in_valid && in_ready;

	assign wr_en_a = accept && !operand_select && a_room;
	assign wr_en_b = accept && operand_select && b_room;
	assign wr_addr = operand_select ? b_base[AW-1:0] : a_base[AW-1:0];
	assign wr_data = limb_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_len_q    <= '0;
			b_len_q    <= '0;
			a_closed_q <= 1'b1;
			b_closed_q <= 1'b1;
			a_sign_q   <= 1'b0;
			job_v_q    <= 1'b0;
			job_la_q   <= '0;
			job_lb_q   <= '0;
			job_neg_q  <= 1'b0;
		end else begin
			if (stat.take)
				job_v_q <= 1'b0;
			if (accept && !operand_select) begin
				a_len_q    <= a_next;
				a_closed_q <= last_limb;
				if (last_limb)
					a_sign_q <= operand_negative;
			end
			if (accept && operand_select) begin
				b_len_q    <= b_next;
				b_closed_q <= last_limb;
				if (last_limb) begin
					job_v_q   <= 1'b1;
					job_la_q  <= a_len_q;
					job_lb_q  <= b_next;
					job_neg_q <= a_sign_q ^ operand_negative;
				end
			end
		end
	end

	assign job_valid = job_v_q;
	assign job_la    = job_la_q;
	assign job_lb    = job_lb_q;
	assign job_neg   = job_neg_q;

endmodule

// ----- rtl/mm_back.sv -----
// Back end: factor stores, schoolbook multiply-accumulate over a shared
// 32x32 multiplier, normalization and limb output. Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_back #(
	parameter int MAX_LIMBS = 64,
	localparam int AW = $clog2(MAX_LIMBS),
	localparam int LW = $clog2(MAX_LIMBS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en_a,
	input  logic               wr_en_b,
	input  logic [AW-1:0]      wr_addr,
	input  mm_pkg::limb_t      wr_data,
	input  logic               job_valid,
	input  logic [LW-1:0]      job_la,
	input  logic [LW-1:0]      job_lb,
	input  logic               job_neg,
	output mm_pkg::back_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output mm_pkg::limb_t      product_limb,
	output logic               product_negative,
	output logic               product_last
);
	import mm_pkg::*;

	localparam int SW = LW + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ROW  = 9'b000000010,
		ST_RD   = 9'b000000100,
		ST_MUL  = 9'b000001000,
		ST_FIN  = 9'b000010000,
		ST_NRD  = 9'b000100000,
		ST_NCHK = 9'b001000000,
		ST_ERD  = 9'b010000000,
		ST_EOUT = 9'b100000000
	} state_t;

	state_t state_q;

	limb_t amem [MAX_LIMBS];
	limb_t bmem [MAX_LIMBS];
	limb_t pmem [MAX_LIMBS];
	logic [MAX_LIMBS-1:0] pvalid_q;

	logic [LW-1:0] la_q, lb_q, i_q, j_q, len_q, k_q, len_init;
	logic [1:0]    step_q;
	logic          neg_q, zero_q;
	limb_t         a_rd_q, b_rd_q, p_rd_q, p_data, carry_q;
	logic          pv_rd_q;
	logic [63:0]   mp_q, mp_next;
	logic [127:0]  acc_q, fin_sum, add_term;
	logic [31:0]   a_half, b_half;
	logic [SW-1:0] ij_sum, row_end, len_sum, nmax;
	logic          inner_go, row_go;
	logic          p_re, p_we;
	logic [AW-1:0] p_raddr, p_waddr;
	limb_t         p_wdata;

	assign nmax     = SW'(MAX_LIMBS);
	assign ij_sum   = {1'b0, i_q} + {1'b0, j_q};
	assign row_end  = {1'b0, i_q} + {1'b0, lb_q};
	assign len_sum  = {1'b0, la_q} + {1'b0, lb_q};
	assign inner_go = (j_q < lb_q) && (ij_sum < nmax);
	assign row_go   = (i_q < la_q) && ({1'b0, i_q} < nmax);

	always_comb begin
		if (len_sum > nmax)
			len_init = LW'(MAX_LIMBS);
		else if (len_sum == '0)
			len_init = LW'(1);
		else
			len_init = len_sum[LW-1:0];
	end

	// Unwritten product entries read as zero.
	assign p_data = pv_rd_q ? p_rd_q : '0;

	// Four partial products: lo*lo, hi*lo, lo*hi, hi*hi.
	assign a_half  = step_q[0] ? a_rd_q[63:32] : a_rd_q[31:0];
	assign b_half  = step_q[1] ? b_rd_q[63:32] : b_rd_q[31:0];
	assign mp_next = a_half * b_half;
	assign add_term = (step_q == 2'd1) ? {64'b0, mp_q} : {32'b0, mp_q, 32'b0};
	assign fin_sum  = acc_q + {mp_q, 64'b0};

	always_comb begin
		p_re    = 1'b0;
		p_raddr = ij_sum[AW-1:0];
		unique case (state_q)
			ST_RD:   p_re = inner_go;
			ST_NRD: begin
				p_re    = 1'b1;
				p_raddr = AW'(len_q - LW'(1));
			end
			ST_ERD: begin
				p_re    = 1'b1;
				p_raddr = k_q[AW-1:0];
			end
			default: p_re = 1'b0;
		endcase
	end

	always_comb begin
		p_we    = 1'b0;
		p_waddr = ij_sum[AW-1:0];
		p_wdata = fin_sum[63:0];
		if (state_q == ST_FIN) begin
			p_we = 1'b1;
		end else if (state_q == ST_RD && !inner_go && row_end < nmax) begin
			// Row carry lands on an entry no earlier row touched.
			p_we    = 1'b1;
			p_waddr = row_end[AW-1:0];
			p_wdata = carry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_a)
			amem[wr_addr] <= wr_data;
		if (wr_en_b)
			bmem[wr_addr] <= wr_data;
		if (state_q == ST_RD) begin
			a_rd_q <= amem[i_q[AW-1:0]];
			b_rd_q <= bmem[j_q[AW-1:0]];
		end
		if (p_we)
			pmem[p_waddr] <= p_wdata;
		if (p_re) begin
			p_rd_q  <= pmem[p_raddr];
			pv_rd_q <= pvalid_q[p_raddr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW)
			carry_q <= '0;
		if (state_q == ST_MUL) begin
			mp_q <= mp_next;
			if (step_q == 2'd0)
				acc_q <= {64'b0, p_data} + {64'b0, carry_q};
			else
				acc_q <= acc_q + add_term;
		end
		if (state_q == ST_FIN)
			carry_q <= fin_sum[127:64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (stat.take) begin
			pvalid_q <= '0;
		end else if (p_we) begin
			pvalid_q[p_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			la_q    <= '0;
			lb_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			len_q   <= '0;
			step_q  <= '0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					la_q    <= job_la;
					lb_q    <= job_lb;
					neg_q   <= job_neg;
					i_q     <= '0;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (row_go) begin
						j_q     <= '0;
						state_q <= ST_RD;
					end else begin
						len_q   <= len_init;
						state_q <= ST_NRD;
					end
				end
				ST_RD: begin
					if (inner_go) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						i_q     <= i_q + LW'(1);
						state_q <= ST_ROW;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					j_q     <= j_q + LW'(1);
					state_q <= ST_RD;
				end
				ST_NRD: state_q <= ST_NCHK;
				ST_NCHK: begin
					if (len_q > LW'(1) && p_data == '0) begin
						len_q   <= len_q - LW'(1);
						state_q <= ST_NRD;
					end else begin
						zero_q  <= (p_data == '0);
						k_q     <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_ERD: state_q <= ST_EOUT;
				ST_EOUT: if (out_ready) begin
					if (product_last) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + LW'(1);
						state_q <= ST_ERD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.take = (state_q == ST_IDLE) && job_valid;
	assign stat.busy = !(state_q == ST_IDLE || state_q == ST_ERD || state_q == ST_EOUT);

	assign out_valid        = (state_q == ST_EOUT);
	assign product_limb     = p_data;
	assign product_negative = neg_q && !zero_q;
	assign product_last     = (k_q == len_q - LW'(1));

	a_take_row: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |=> state_q == ST_ROW)
		else $error("job taken but row loop not started");

	a_pwrite_busy: assert property (@(posedge clk) disable iff (!arst_n)
		p_we |-> stat.busy)
		else $error("product store written outside compute");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (k_q < len_q) && (len_q != '0))
		else $error("emit index beyond product length");

	a_zero_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && len_q == LW'(1) && product_limb == '0 |-> !product_negative)
		else $error("zero product marked negative");

endmodule

// ----- rtl/multiprecision_multiplier.sv -----
// Multiprecision sign-magnitude multiplier, top level.
// Instantiates mm_front and mm_back; depends on mm_pkg.
`timescale 1ns / 1ps

// Schoolbook multiplier for sign-magnitude integers of up to MAX_LIMBS 64-bit
// limbs. Load the first factor (operand_select 0) and then the second
// (operand_select 1), low limb first, each closed by last_limb with its sign.
// Closing the second factor starts a product; the first factor stays stored,
// so further second factors reuse it. Limbs past MAX_LIMBS are dropped. The
// product is truncated to MAX_LIMBS limbs, stripped of leading zero limbs
// (at least one kept) and streamed low limb first with product_last on the
// top limb; a zero product is never negative. The product is built with one
// 32x32 multiplier shared over four partial products per limb pair: each pair
// is read, multiplied and accumulated, and written back with its carry, and
// each row ends with a carry write. Normalization then drops leading zero
// limbs one at a time, and each emitted limb is read and then offered. The
// front end may load the next operands while product limbs drain, but stalls
// input while the multiply or normalization runs or a product job waits.

module multiprecision_multiplier #(
	parameter int MAX_LIMBS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          operand_select,
	input  mm_pkg::limb_t limb_value,
	input  logic          operand_negative,
	input  logic          last_limb,
	output logic          out_valid,
	input  logic          out_ready,
	output mm_pkg::limb_t product_limb,
	output logic          product_negative,
	output logic          product_last
);
	import mm_pkg::*;

	localparam int AW = $clog2(MAX_LIMBS);
	localparam int LW = $clog2(MAX_LIMBS + 1);

	back_stat_t    stat;
	logic          wr_en_a, wr_en_b;
	logic [AW-1:0] wr_addr;
	limb_t         wr_data;
	logic          job_valid, job_neg;
	logic [LW-1:0] job_la, job_lb;

	// Front end: item intake, store writes, single-entry job queue.
	mm_front #(.MAX_LIMBS(MAX_LIMBS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operand_select   (operand_select),
		.limb_value       (limb_value),
		.operand_negative (operand_negative),
		.last_limb        (last_limb),
		.stat             (stat),
		.wr_en_a          (wr_en_a),
		.wr_en_b          (wr_en_b),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.job_valid        (job_valid),
		.job_la           (job_la),
		.job_lb           (job_lb),
		.job_neg          (job_neg)
	);

	// Back end: multiply-accumulate, normalize, emit.
	mm_back #(.MAX_LIMBS(MAX_LIMBS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en_a          (wr_en_a),
		.wr_en_b          (wr_en_b),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.job_valid        (job_valid),
		.job_la           (job_la),
		.job_lb           (job_lb),
		.job_neg          (job_neg),
		.stat             (stat),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.product_limb     (product_limb),
		.product_negative (product_negative),
		.product_last     (product_last)
	);

endmodule
